/* rtl/bcd_pkg.sv */
package bcd_pkg;

	localparam int SMP_W          = 32;  // raw sample width
	localparam int MEAN_W         = 41;  // mean_value width
	localparam int MEAN_TDATA_W   = 48;  // mean_value padded to bytes
	localparam int FACTOR_W       = 7;   // decim_factor register width
	localparam int KIND_W         = 3;   // sample_kind register width
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 7;
	localparam int DEF_MAX_FACTOR = 64;
	localparam int DEF_FRAC_BITS  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KIND   = 1'b1;

	localparam logic [FACTOR_W-1:0] FACTOR_RST = 7'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_U8  = 3'd0,
		KIND_U16 = 3'd1,
		KIND_U32 = 3'd2,
		KIND_I8  = 3'd3,
		KIND_I16 = 3'd4,
		KIND_I32 = 3'd5
	} kind_t;

	typedef enum logic {
		ST_ACC = 1'b0,
		ST_DIV = 1'b1
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic acc_en;     // take the presented sample
		logic start_div;  // sample closes the group: load the divider
		logic div_step;   // one restoring division step
		logic out_load;   // move quotient into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic close;      // presented sample completes the group
		logic out_free;   // output register can take a new result
	} sts_t;

endpackage

/* rtl/boxcar_decimator.sv */
// Boxcar decimator: sums runs of decim_factor samples, emits sum*2^FRAC_BITS/N.
// The closing sample starts DIV_STEPS divider steps; the result is then loaded
//   when the output is free (DIV_STEPS = sum width + FRAC_BITS = 47 by default).
// Throughput: one sample per cycle inside a group; the closing sample holds
//   s_tready low while the bit-serial divider runs and until the result is loaded.
// Reset (arst_n, async): decim_factor 1, sample_kind u16, sum/count cleared.
module boxcar_decimator
	import bcd_pkg::*;
#(
	parameter int MAX_FACTOR = DEF_MAX_FACTOR,  // 2..256
	parameter int FRAC_BITS  = DEF_FRAC_BITS    // 0..16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// config write port: index 0 decim_factor, 1 sample_kind
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// sample requests
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [SMP_W-1:0]        s_tdata,   // [31:0] sample
	input  logic                    s_tlast,   // frame_end
	// mean requests
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [MEAN_TDATA_W-1:0] m_tdata,   // [40:0] mean_value, [47:41] zero
	output logic                    m_tlast    // frame_last
);

	// dividend is the group sum magnitude with FRAC_BITS zeros appended;
	// the divider produces one quotient bit per step
	localparam int SUM_W     = SMP_W + $clog2(MAX_FACTOR) + 1;
	localparam int DIV_STEPS = SUM_W + FRAC_BITS;

	cmd_t                     cmd;
	sts_t                     sts;
	logic signed [MEAN_W-1:0] mean_value;

	bcd_ctrl #(
		.DIV_STEPS (DIV_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// accumulator, divider and output register live in the datapath;
	// the output register lets a new group accumulate while a mean waits
	bcd_datapath #(
		.MAX_FACTOR (MAX_FACTOR),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (s_tdata),
		.frame_end  (s_tlast),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.mean_value (mean_value),
		.frame_last (m_tlast)
	);

	assign m_tdata = {{(MEAN_TDATA_W-MEAN_W){1'b0}}, mean_value};

endmodule

/* rtl/bcd_ctrl.sv */
module bcd_ctrl
	import bcd_pkg::*;
#(
	parameter int DIV_STEPS = 47
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int STEP_W = $clog2(DIV_STEPS + 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS);

	state_t           state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_ACC: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.acc_en = 1'b1;
					if (sts.close) begin
						cmd.start_div = 1'b1;
						step_d        = '0;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (step_q != STEP_LAST) begin
					cmd.div_step = 1'b1;
					step_d       = step_q + 1'b1;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

endmodule

/* rtl/bcd_datapath.sv */
module bcd_datapath
	import bcd_pkg::*;
#(
	parameter int MAX_FACTOR = DEF_MAX_FACTOR,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic [SMP_W-1:0]        sample,
	input  logic                    frame_end,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [MEAN_W-1:0] mean_value,
	output logic                    frame_last
);

	localparam int CNT_W  = $clog2(MAX_FACTOR + 1);
	localparam int SUM_W  = SMP_W + $clog2(MAX_FACTOR) + 1;
	localparam int DIVD_W = SUM_W + FRAC_BITS;
	localparam int QX_W   = (DIVD_W > MEAN_W) ? DIVD_W : MEAN_W;

	// configuration
	logic [FACTOR_W-1:0] factor_q;
	kind_t               kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RST;
			kind_q   <= KIND_U16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FACTOR: factor_q <= cfg_data[FACTOR_W-1:0];
				REG_KIND:   kind_q   <= kind_t'(cfg_data[KIND_W-1:0]);
				default:    ;
			endcase
		end
	end

	logic [CNT_W-1:0] eff_n;
	always_comb begin
		if (factor_q == '0) begin
			eff_n = CNT_W'(1);
		end else if (32'(factor_q) > 32'(MAX_FACTOR)) begin
			eff_n = CNT_W'(MAX_FACTOR);
		end else begin
			eff_n = CNT_W'(factor_q);
		end
	end

	// sample read, 33 bits so u32 stays positive
	logic signed [SMP_W:0] smp_x;
	always_comb begin
		unique case (kind_q)
			KIND_U8:  smp_x = (SMP_W+1)'(sample[7:0]);
			KIND_U16: smp_x = (SMP_W+1)'(sample[15:0]);
			KIND_I8:  smp_x = (SMP_W+1)'(signed'(sample[7:0]));
			KIND_I16: smp_x = (SMP_W+1)'(signed'(sample[15:0]));
			KIND_I32: smp_x = (SMP_W+1)'(signed'(sample));
			default:  smp_x = (SMP_W+1)'(sample);  // u32 and unused codes
		endcase
	end

	// accumulator
	logic signed [SUM_W-1:0] sum_q, sum_new;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W:0]          cnt_inc;
	logic [SUM_W-1:0]        mag;

	assign sum_new   = sum_q + SUM_W'(smp_x);
	assign cnt_inc   = {1'b0, cnt_q} + 1'b1;
	assign sts.close = cnt_inc >= {1'b0, eff_n};
	assign mag       = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.acc_en) begin
			if (sts.close || frame_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_new;
				cnt_q <= cnt_inc[CNT_W-1:0];
			end
		end
	end

	// restoring divider, one quotient bit per step; dividend shifts out
	// as quotient shifts in
	logic [DIVD_W-1:0] divd_q;
	logic [CNT_W-1:0]  rem_q, div_n_q;
	logic              neg_q, last_q;
	logic [CNT_W:0]    rem_sh, rem_sub;
	logic              fits;

	assign rem_sh  = {rem_q, divd_q[DIVD_W-1]};
	assign fits    = rem_sh >= {1'b0, div_n_q};
	assign rem_sub = rem_sh - {1'b0, div_n_q};

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			divd_q  <= DIVD_W'(mag) << FRAC_BITS;
			rem_q   <= '0;
			div_n_q <= eff_n;
			neg_q   <= sum_new[SUM_W-1];
			last_q  <= frame_end;
		end else if (cmd.div_step) begin
			divd_q <= {divd_q[DIVD_W-2:0], fits};
			rem_q  <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	// output register
	logic [QX_W-1:0] q_ext, q_sgn;
	assign q_ext = QX_W'(divd_q);
	assign q_sgn = neg_q ? -q_ext : q_ext;

	logic              out_valid_q;
	logic [MEAN_W-1:0] mean_q;
	logic              flast_q;

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_q  <= q_sgn[MEAN_W-1:0];
			flast_q <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_value = signed'(mean_q);
	assign frame_last = flast_q;

endmodule
